/* rtl/dvsp_pkg.sv */
package dvsp_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned FieldW   = 10;
  localparam int unsigned PackedW  = 3 * FieldW;
  localparam int unsigned AccW     = FieldW + 4;

  localparam logic [CharW-1:0]  DOT_CHAR  = 8'h2E;
  localparam logic [CharW-1:0]  ZERO_CHAR = 8'h30;
  localparam logic [CharW-1:0]  NINE_CHAR = 8'h39;
  localparam logic [AccW-1:0]   FIELD_MAX = 14'd1023;

  localparam logic [1:0] POS_MAJOR = 2'd0;
  localparam logic [1:0] POS_MINOR = 2'd1;
  localparam logic [1:0] POS_PATCH = 2'd2;

  typedef logic [FieldW-1:0] field_t;

  typedef struct packed {
    logic [PackedW-1:0] packed_version;
    logic               invalid;
  } result_t;

endpackage

/* rtl/dotted_version_string_packer.sv */
// Path: a result passes the input register, then the result register.
// Throughput: one character per cycle unless in_stall_o is high; parse state updates in a single pass.
// Reset: rst_ni is asynchronous, active low; it empties both registers and
//   clears all parse state.
module dotted_version_string_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dvsp_pkg::CharW-1:0]     character_i,
  input  logic                           final_char_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dvsp_pkg::PackedW-1:0]   packed_version_o,
  output logic                           invalid_o
);

  logic                         in_valid_q, in_valid_d;
  logic [dvsp_pkg::CharW-1:0]   char_q;
  logic                         final_q;
  logic                         in_xfer;
  logic                         proc_fire;
  logic                         out_ready;
  dvsp_pkg::result_t            parse_res;
  dvsp_pkg::result_t            out_res;

  assign proc_fire  = in_valid_q && (!final_q || out_ready);
  assign in_stall_o = in_valid_q && !proc_fire;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else begin
      in_valid_d = in_valid_q && !proc_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      char_q  <= character_i;
      final_q <= final_char_i;
    end
  end

  dvsp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (proc_fire),
    .char_i  (char_q),
    .final_i (final_q),
    .res_o   (parse_res)
  );

  dvsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (proc_fire && final_q),
    .res_i       (parse_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign packed_version_o = out_res.packed_version;
  assign invalid_o        = out_res.invalid;

endmodule

/* rtl/dvsp_parser.sv */
module dvsp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [dvsp_pkg::CharW-1:0]   char_i,
  input  logic                         final_i,
  output dvsp_pkg::result_t            res_o
);

  dvsp_pkg::field_t field_q [3];
  dvsp_pkg::field_t field_d [3];
  logic [1:0]       pos_q, pos_d;
  logic             digit_q, digit_d;
  logic             err_q, err_d;
  logic             skip_q, skip_d;

  logic [1:0]                 pos_c;
  dvsp_pkg::field_t           cur;
  logic [dvsp_pkg::AccW-1:0]  acc;
  logic [3:0]                 digit_val;
  logic                       is_digit;
  logic                       bad;

  assign pos_c     = (pos_q > dvsp_pkg::POS_PATCH) ? dvsp_pkg::POS_PATCH : pos_q;
  assign cur       = field_q[pos_c];
  assign digit_val = 4'(char_i - dvsp_pkg::ZERO_CHAR);
  assign is_digit  = (char_i >= dvsp_pkg::ZERO_CHAR) && (char_i <= dvsp_pkg::NINE_CHAR);
  assign acc       = ({4'b0, cur} << 3) + ({4'b0, cur} << 1)
                   + {{(dvsp_pkg::AccW-4){1'b0}}, digit_val};

  // character update, before the end-of-string check
  always_comb begin
    field_d = field_q;
    pos_d   = pos_q;
    digit_d = digit_q;
    err_d   = err_q;
    skip_d  = skip_q;
    if (!err_q && !skip_q) begin
      if (char_i == dvsp_pkg::DOT_CHAR) begin
        if (!digit_q) begin
          err_d = 1'b1;
        end else if (pos_c == dvsp_pkg::POS_PATCH) begin
          skip_d = 1'b1;
        end else begin
          pos_d   = pos_c + 2'd1;
          digit_d = 1'b0;
        end
      end else if (!is_digit) begin
        err_d = 1'b1;
      end else if (acc > dvsp_pkg::FIELD_MAX) begin
        err_d = 1'b1;
      end else begin
        field_d[pos_c] = acc[dvsp_pkg::FieldW-1:0];
        digit_d        = 1'b1;
      end
    end
  end

  assign bad = err_d || (pos_d < dvsp_pkg::POS_MINOR) || !digit_d;
  assign res_o.invalid        = bad;
  assign res_o.packed_version = bad ? '0 : {field_d[0], field_d[1], field_d[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q <= '{default: '0};
      pos_q   <= '0;
      digit_q <= 1'b0;
      err_q   <= 1'b0;
      skip_q  <= 1'b0;
    end else if (fire_i) begin
      if (final_i) begin
        field_q <= '{default: '0};
        pos_q   <= '0;
        digit_q <= 1'b0;
        err_q   <= 1'b0;
        skip_q  <= 1'b0;
      end else begin
        field_q <= field_d;
        pos_q   <= pos_d;
        digit_q <= digit_d;
        err_q   <= err_d;
        skip_q  <= skip_d;
      end
    end
  end

endmodule

/* rtl/dvsp_out_reg.sv */
module dvsp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  dvsp_pkg::result_t   res_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dvsp_pkg::result_t   res_o
);

  logic              valid_q, valid_d;
  dvsp_pkg::result_t res_q;

  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else begin
      valid_d = valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule
